FILE: hw/rtl/vfld_pkg.sv
// ----------------------------------------------------------------------------
// vfld_pkg
// shared types, codes and arithmetic helpers for the frame to lightbar decoder
// ----------------------------------------------------------------------------
`default_nettype none

package vfld_pkg;

  // field widths
  localparam int unsigned IdW     = 11;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ActionW = 4;
  localparam int unsigned LevelW  = 7;
  localparam int unsigned TempW   = 16;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [IdW-1:0]     id_t;
  typedef logic [ActionW-1:0] action_t;
  typedef logic [LevelW-1:0]  level_t;
  typedef logic signed [TempW-1:0] temp_t;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_CONTROLLER_ID  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BATTERY_ID     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LEFT_MOTOR_ID  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_RIGHT_MOTOR_ID = 2'd3;

  localparam id_t CONTROLLER_ID_RST  = 11'd0;
  localparam id_t BATTERY_ID_RST     = 11'd1;
  localparam id_t LEFT_MOTOR_ID_RST  = 11'd2;
  localparam id_t RIGHT_MOTOR_ID_RST = 11'd3;

  // result action codes
  localparam action_t ACT_NONE        = 4'd0;
  localparam action_t ACT_BLINK       = 4'd1;
  localparam action_t ACT_SOLID       = 4'd2;
  localparam action_t ACT_OFF         = 4'd3;
  localparam action_t ACT_FAULT_CLEAR = 4'd4;
  localparam action_t ACT_FAULT_SET   = 4'd5;
  localparam action_t ACT_TEMP        = 4'd6;
  localparam action_t ACT_BATTERY     = 4'd7;
  localparam action_t ACT_INVALID     = 4'd8;

  // controller command codes in body byte 0
  localparam logic [ByteW-1:0] CMD_BLINK       = 8'd0;
  localparam logic [ByteW-1:0] CMD_SOLID       = 8'd1;
  localparam logic [ByteW-1:0] CMD_OFF         = 8'd2;
  localparam logic [ByteW-1:0] CMD_FAULT_CLEAR = 8'd3;
  localparam logic [ByteW-1:0] CMD_FAULT_SET   = 8'd4;

  localparam logic [ByteW-1:0] TEMP_MODIFIER = 8'd74;

  localparam temp_t TEMP_RST = -16'sd32767;
  localparam temp_t TEMP_MIN = 16'sd17250;
  localparam temp_t TEMP_MAX = 16'sd20250;

  localparam int unsigned TempLevelMax = 30;
  localparam int unsigned BattLevelMax = 76;

  // floor(3*soc/10): 3*soc stays below 1029, so *205 >> 11 is exact
  function automatic level_t battery_level(input logic [ByteW-1:0] soc);
    logic [9:0]  tri_soc;
    logic [17:0] prod;
    tri_soc = {2'b00, soc} + {1'b0, soc, 1'b0};
    prod    = {8'd0, tri_soc} * 18'd205;
    return prod[17:11];
  endfunction

  // clamp to 17250..20250, then (t-17250)/100 by *5243 >> 19
  function automatic level_t temp_level(input temp_t t);
    temp_t       tc;
    logic [15:0] diff;
    logic [24:0] prod;
    if (t < TEMP_MIN) begin
      tc = TEMP_MIN;
    end else if (t > TEMP_MAX) begin
      tc = TEMP_MAX;
    end else begin
      tc = t;
    end
    diff = 16'(tc - TEMP_MIN);
    prod = {13'd0, diff[11:0]} * 25'd5243;
    return {2'b00, prod[23:19]};
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/vehicle_frame_to_lightbar_decoder_core.sv
// an accepted frame request passes through the input register and then the result register to out_valid
// throughput: one frame per cycle while out_stall is low, set by the input register and result register pair
// each frame gives exactly one result; out_stall backs up through the result register
// reset (synchronous, rst_n low): pipeline empty, ids 0/1/2/3, both motor temps -32767
// ----------------------------------------------------------------------------
// vehicle_frame_to_lightbar_decoder_core
// decodes controller, battery and motor frames into lightbar actions and levels
// ----------------------------------------------------------------------------
`default_nettype none

module vehicle_frame_to_lightbar_decoder_core
  import vfld_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // configuration write port
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [IdW-1:0]      cfg_data,
  // frame request channel
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire logic [IdW-1:0]      in_frame_id,
  input  wire logic [ByteW-1:0]    in_byte_zero,
  input  wire logic [ByteW-1:0]    in_byte_one,
  input  wire logic [ByteW-1:0]    in_byte_two,
  // result channel
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      logic [ActionW-1:0]  out_action,
  output      logic [LevelW-1:0]   out_level
);

  // configured identifiers
  id_t ctrl_id_r, batt_id_r, left_id_r, right_id_r;

  // input register stage
  logic             s1_valid_r;
  id_t              s1_id_r;
  logic [ByteW-1:0] s1_b0_r, s1_b1_r, s1_b2_r;

  // motor temperature state
  temp_t left_temp_r, right_temp_r;
  temp_t left_temp_nxt, right_temp_nxt;

  // result register
  logic    out_valid_r;
  action_t out_action_r, action_nxt;
  level_t  out_level_r, level_nxt;

  logic in_acc;
  logic out_ld;

  // result register frees when empty or when its request is taken this cycle
  assign out_ld   = s1_valid_r && (!out_valid_r || !out_stall);
  // input register takes a new request when empty or when it moves on
  assign in_stall = s1_valid_r && !out_ld;
  assign in_acc   = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // configuration registers, to be written only while the block is idle; the block does not enforce this
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_id_r  <= CONTROLLER_ID_RST;
      batt_id_r  <= BATTERY_ID_RST;
      left_id_r  <= LEFT_MOTOR_ID_RST;
      right_id_r <= RIGHT_MOTOR_ID_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CONTROLLER_ID:  ctrl_id_r  <= cfg_data;
        CFG_BATTERY_ID:     batt_id_r  <= cfg_data;
        CFG_LEFT_MOTOR_ID:  left_id_r  <= cfg_data;
        CFG_RIGHT_MOTOR_ID: right_id_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (out_ld) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_id_r <= in_frame_id;
      s1_b0_r <= in_byte_zero;
      s1_b1_r <= in_byte_one;
      s1_b2_r <= in_byte_two;
    end
  end

  // ---------------------------------------------------------------------------
  // decode: identifier match in priority order, then per-kind work
  // ---------------------------------------------------------------------------
  always_comb begin
    temp_t new_temp;
    temp_t hot_temp;
    new_temp       = temp_t'({s1_b2_r, s1_b1_r});
    action_nxt     = ACT_NONE;
    level_nxt      = '0;
    left_temp_nxt  = left_temp_r;
    right_temp_nxt = right_temp_r;
    hot_temp       = left_temp_r;

    if (s1_id_r == ctrl_id_r) begin
      case (s1_b0_r)
        CMD_BLINK:       action_nxt = ACT_BLINK;
        CMD_SOLID:       action_nxt = ACT_SOLID;
        CMD_OFF:         action_nxt = ACT_OFF;
        CMD_FAULT_CLEAR: action_nxt = ACT_FAULT_CLEAR;
        CMD_FAULT_SET:   action_nxt = ACT_FAULT_SET;
        default:         action_nxt = ACT_INVALID;
      endcase
    end else if (s1_id_r == batt_id_r) begin
      action_nxt = ACT_BATTERY;
      level_nxt  = battery_level(s1_b0_r);
    end else if ((s1_id_r == left_id_r || s1_id_r == right_id_r) &&
                 s1_b0_r == TEMP_MODIFIER) begin
      // left identifier wins when both motors share one
      if (s1_id_r == left_id_r) begin
        left_temp_nxt = new_temp;
      end else begin
        right_temp_nxt = new_temp;
      end
      // hotter of the two motors, an unreported one still holds its sentinel
      hot_temp   = (left_temp_nxt > right_temp_nxt) ? left_temp_nxt : right_temp_nxt;
      action_nxt = ACT_TEMP;
      level_nxt  = temp_level(hot_temp);
    end
  end

  // ---------------------------------------------------------------------------
  // state and result register, both advance together when the frame moves on
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_temp_r  <= TEMP_RST;
      right_temp_r <= TEMP_RST;
    end else if (out_ld) begin
      left_temp_r  <= left_temp_nxt;
      right_temp_r <= right_temp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_action_r <= action_nxt;
      out_level_r  <= level_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_action = out_action_r;
  assign out_level  = out_level_r;

`ifndef NO_ASSERTIONS
  // a level is reported only for temperature and battery results
  a_level_only_for_levels: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !(out_action_r == ACT_TEMP || out_action_r == ACT_BATTERY)
      |-> out_level_r == '0)
    else $error("level set on a non-level action");

  a_temp_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_action_r == ACT_TEMP |-> out_level_r <= level_t'(TempLevelMax))
    else $error("temperature level out of range");

  a_batt_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_action_r == ACT_BATTERY |-> out_level_r <= level_t'(BattLevelMax))
    else $error("battery level out of range");

  // motor state only changes when a temperature result is produced
  a_temp_state_moves: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(left_temp_r) || !$stable(right_temp_r)
      |-> $past(out_ld) && out_action_r == ACT_TEMP)
    else $error("motor temperature changed without a temperature result");

  // the input side only stalls while the input register is full and blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled with room downstream");
`endif

endmodule

`default_nettype wire

FILE: verif/vehicle_frame_to_lightbar_decoder_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vehicle_frame_to_lightbar_decoder_core_test
// self-checking bench: random frame requests with bursty sends and a stalling
// result side, each result checked against a local decode of the frame
// ----------------------------------------------------------------------------

module vehicle_frame_to_lightbar_decoder_core_test;
  import vfld_pkg::*;

  localparam int TempStep = 100;

  typedef struct packed {
    id_t              frame_id;
    logic [ByteW-1:0] byte_zero;
    logic [ByteW-1:0] byte_one;
    logic [ByteW-1:0] byte_two;
  } bus_frame_t;

  typedef struct packed {
    action_t action;
    level_t  level;
  } lightbar_result_t;

  // result side stall patterns
  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_COIN,
    FLOW_HEAVY,
    FLOW_TICK
  } flow_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // configuration port
  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = CFG_CONTROLLER_ID;
  id_t                cfg_data  = '0;

  // request channel
  logic             in_valid     = 1'b0;
  logic             in_stall;
  id_t              in_frame_id  = '0;
  logic [ByteW-1:0] in_byte_zero = '0;
  logic [ByteW-1:0] in_byte_one  = '0;
  logic [ByteW-1:0] in_byte_two  = '0;

  // result channel
  logic           out_valid;
  logic           out_stall = 1'b0;
  action_t        out_action;
  level_t         out_level;

  // local copy of the decoder's registers and motor temperatures
  id_t   ctrl_id_m  = CONTROLLER_ID_RST;
  id_t   batt_id_m  = BATTERY_ID_RST;
  id_t   left_id_m  = LEFT_MOTOR_ID_RST;
  id_t   right_id_m = RIGHT_MOTOR_ID_RST;
  temp_t left_temp_m  = TEMP_RST;
  temp_t right_temp_m = TEMP_RST;

  bus_frame_t       pending_frames[$];
  lightbar_result_t predicted_results[$];
  bus_frame_t       cur_frame;

  int unsigned frames_queued   = 0;
  int unsigned frames_accepted = 0;
  int unsigned fail_count      = 0;
  int unsigned burst_left      = 0;
  int unsigned gap_left        = 0;
  int unsigned stall_cycle     = 0;
  flow_t       stall_mode      = FLOW_FREE;

  vehicle_frame_to_lightbar_decoder_core uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_frame_id  (in_frame_id),
    .in_byte_zero (in_byte_zero),
    .in_byte_one  (in_byte_one),
    .in_byte_two  (in_byte_two),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_action   (out_action),
    .out_level    (out_level)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decode one accepted frame; motor readings update the local temperatures
  function automatic lightbar_result_t decode_frame(input bus_frame_t f);
    lightbar_result_t r;
    int hottest;
    r.action = ACT_NONE;
    r.level  = '0;
    if (f.frame_id == ctrl_id_m) begin
      case (f.byte_zero)
        CMD_BLINK:       r.action = ACT_BLINK;
        CMD_SOLID:       r.action = ACT_SOLID;
        CMD_OFF:         r.action = ACT_OFF;
        CMD_FAULT_CLEAR: r.action = ACT_FAULT_CLEAR;
        CMD_FAULT_SET:   r.action = ACT_FAULT_SET;
        default:         r.action = ACT_INVALID;
      endcase
    end else if (f.frame_id == batt_id_m) begin
      // charge scaled to three tenths, rounded down
      r.action = ACT_BATTERY;
      r.level  = level_t'((3 * int'(f.byte_zero)) / 10);
    end else if ((f.frame_id == left_id_m || f.frame_id == right_id_m) &&
                 f.byte_zero == TEMP_MODIFIER) begin
      // left wins when both motor ids are the same
      if (f.frame_id == left_id_m) begin
        left_temp_m = $signed({f.byte_two, f.byte_one});
      end else begin
        right_temp_m = $signed({f.byte_two, f.byte_one});
      end
      // an unreported motor still holds its sentinel, so the other one decides
      hottest = (left_temp_m > right_temp_m) ? left_temp_m : right_temp_m;
      if (hottest < TEMP_MIN) begin
        hottest = TEMP_MIN;
      end
      if (hottest > TEMP_MAX) begin
        hottest = TEMP_MAX;
      end
      r.action = ACT_TEMP;
      r.level  = level_t'((hottest - TEMP_MIN) / TempStep);
    end
    return r;
  endfunction

  task automatic push_frame(input id_t id, input logic [ByteW-1:0] b0,
                            input logic [ByteW-1:0] b1, input logic [ByteW-1:0] b2);
    bus_frame_t f;
    f.frame_id  = id;
    f.byte_zero = b0;
    f.byte_one  = b1;
    f.byte_two  = b2;
    pending_frames.push_back(f);
    frames_queued++;
  endtask

  task automatic push_motor(input id_t id, input temp_t t);
    push_frame(id, TEMP_MODIFIER, t[7:0], t[15:8]);
  endtask

  // mostly around the clamp window, some anywhere, some right on the edges
  function automatic temp_t pick_temperature();
    temp_t t;
    case ($urandom_range(0, 3))
      0, 1: t = 16'($urandom_range(17000, 20500));
      2:    t = 16'($urandom);
      default: begin
        case ($urandom_range(0, 7))
          0: t = TEMP_MIN;
          1: t = TEMP_MIN + 16'sd99;
          2: t = TEMP_MIN + 16'sd100;
          3: t = TEMP_MAX - 16'sd1;
          4: t = TEMP_MAX;
          5: t = TEMP_MAX + 16'sd1;
          6: t = 16'sh8000;
          default: t = 16'sh7fff;
        endcase
      end
    endcase
    return t;
  endfunction

  // a well-formed frame for one of the configured ids most of the time
  task automatic push_random_frame();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      push_frame(ctrl_id_m,
                 ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4)),
                 8'($urandom), 8'($urandom));
    end else if (pick < 33) begin
      push_frame(batt_id_m, 8'($urandom), 8'($urandom), 8'($urandom));
    end else if (pick < 85) begin
      if ($urandom_range(0, 9) == 0) begin
        // motor frame that carries something other than a temperature
        push_frame($urandom_range(0, 1) ? left_id_m : right_id_m,
                   8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        push_motor($urandom_range(0, 1) ? left_id_m : right_id_m, pick_temperature());
      end
    end else begin
      push_frame(11'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // sampled just after an edge, so no race with the clocked blocks
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (frames_accepted != frames_queued || predicted_results.size() != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input id_t val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_CONTROLLER_ID: ctrl_id_m  = val;
      CFG_BATTERY_ID:    batt_id_m  = val;
      CFG_LEFT_MOTOR_ID: left_id_m  = val;
      default:           right_id_m = val;
    endcase
  endtask

  // only called with the pipeline drained
  task automatic set_ids(input id_t ctrl, input id_t batt, input id_t left, input id_t right);
    write_reg(CFG_CONTROLLER_ID, ctrl);
    write_reg(CFG_BATTERY_ID, batt);
    write_reg(CFG_LEFT_MOTOR_ID, left);
    write_reg(CFG_RIGHT_MOTOR_ID, right);
    @(posedge clk);
    cfg_we <= 1'b0;
    #1;
  endtask

  // sender: bursts of requests with random gaps, payload held while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_results.push_back(decode_frame(cur_frame));
        frames_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_frames.size() != 0) begin
          cur_frame    = pending_frames.pop_front();
          in_frame_id  <= cur_frame.frame_id;
          in_byte_zero <= cur_frame.byte_zero;
          in_byte_one  <= cur_frame.byte_one;
          in_byte_two  <= cur_frame.byte_two;
          in_valid     <= 1'b1;
          if (burst_left <= 1) begin
            // new burst; a third of them follow with no gap at all
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each accepted result and picks a new random stall pattern as it runs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          $error("result with no request pending: action %0d level %0d",
                 out_action, out_level);
          fail_count++;
        end else begin
          lightbar_result_t exp_r;
          exp_r = predicted_results.pop_front();
          if (out_action !== exp_r.action) begin
            $error("action: expected %0d, got %0d", exp_r.action, out_action);
            fail_count++;
          end
          if (out_level !== exp_r.level) begin
            $error("level: expected %0d, got %0d", exp_r.level, out_level);
            fail_count++;
          end
        end
      end
      stall_cycle++;
      if (stall_cycle % 80 == 0) begin
        stall_mode = flow_t'($urandom_range(0, 3));
      end
      case (stall_mode)
        FLOW_FREE:  out_stall <= 1'b0;
        FLOW_COIN:  out_stall <= ($urandom_range(0, 1) == 1);
        FLOW_HEAVY: out_stall <= ($urandom_range(0, 9) < 8);
        default:    out_stall <= (stall_cycle % 3 == 0);
      endcase
    end
  end

  // stimulus and end of run
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    #1;

    // reset ids 0..3: left motor reports first while right is still unreported
    push_motor(LEFT_MOTOR_ID_RST, 16'sd18000);
    push_motor(RIGHT_MOTOR_ID_RST, 16'sh8000);
    push_motor(RIGHT_MOTOR_ID_RST, TEMP_MAX);
    push_motor(LEFT_MOTOR_ID_RST, 16'sh7fff);
    push_motor(LEFT_MOTOR_ID_RST, TEMP_MIN);
    push_motor(RIGHT_MOTOR_ID_RST, TEMP_MIN + 16'sd99);
    push_motor(LEFT_MOTOR_ID_RST, TEMP_MIN + 16'sd100);
    // motor frame without the temperature modifier
    push_frame(LEFT_MOTOR_ID_RST, TEMP_MODIFIER - 8'd1, 8'hff, 8'hff);
    // every controller code, then unknown codes
    push_frame(CONTROLLER_ID_RST, CMD_BLINK, 8'h00, 8'h00);
    push_frame(CONTROLLER_ID_RST, CMD_SOLID, 8'h00, 8'h00);
    push_frame(CONTROLLER_ID_RST, CMD_OFF, 8'h00, 8'h00);
    push_frame(CONTROLLER_ID_RST, CMD_FAULT_CLEAR, 8'h00, 8'h00);
    push_frame(CONTROLLER_ID_RST, CMD_FAULT_SET, 8'h00, 8'h00);
    push_frame(CONTROLLER_ID_RST, CMD_FAULT_SET + 8'd1, 8'hff, 8'hff);
    push_frame(CONTROLLER_ID_RST, 8'hff, 8'hff, 8'hff);
    // battery charge extremes and the rounding step
    push_frame(BATTERY_ID_RST, 8'd0, 8'h00, 8'h00);
    push_frame(BATTERY_ID_RST, 8'd255, 8'hff, 8'hff);
    push_frame(BATTERY_ID_RST, 8'd9, 8'h00, 8'h00);
    push_frame(BATTERY_ID_RST, 8'd10, 8'h00, 8'h00);
    // identifier that matches nothing
    push_frame(11'h7ff, 8'hff, 8'hff, 8'hff);
    push_frame(11'h7ff, TEMP_MODIFIER, 8'h00, 8'h00);
    wait_idle();

    // all ids equal at the top value: controller takes priority
    set_ids(11'h7ff, 11'h7ff, 11'h7ff, 11'h7ff);
    push_motor(11'h7ff, TEMP_MAX);
    repeat (100) push_random_frame();
    wait_idle();

    // battery at the top, both motors on one id: left takes priority
    set_ids(11'h000, 11'h7ff, 11'h400, 11'h400);
    repeat (100) push_random_frame();
    wait_idle();

    set_ids(11'h7ff, 11'h000, 11'h001, 11'h7fe);
    repeat (100) push_random_frame();
    wait_idle();

    // random id sets
    repeat (4) begin
      set_ids(11'($urandom), 11'($urandom), 11'($urandom), 11'($urandom));
      repeat (110) push_random_frame();
      wait_idle();
    end

    // back to the reset ids
    set_ids(CONTROLLER_ID_RST, BATTERY_ID_RST, LEFT_MOTOR_ID_RST, RIGHT_MOTOR_ID_RST);
    repeat (60) push_random_frame();
    wait_idle();

    // catch any stray result still coming out of the pipeline
    repeat (8) @(posedge clk);
    #1;
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
